// File: rtl/chbm_pkg.sv
`default_nettype none
package chbm_pkg;

  // Field and register widths
  localparam int CH_BITS      = 8;
  localparam int Q_BITS       = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int REQ_BITS     = 2;
  localparam int QUO_BITS     = 2 * Q_BITS;

  // Default structural parameters
  localparam int BITS_PER_CHANNEL_DEF = 4;
  localparam int COUNT_BITS_DEF       = 20;

  // Register reset values
  localparam logic [Q_BITS-1:0] ALPHA_RESET     = 16'd655;
  localparam logic [Q_BITS-1:0] THRESHOLD_RESET = 16'd66;
  localparam logic [Q_BITS-1:0] WARMUP_RESET    = 16'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ALPHA     = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_WARMUP    = 2'd2
  } cfg_idx_t;

  // Request codes
  typedef enum logic [REQ_BITS-1:0] {
    REQ_SAMPLE   = 2'd0,
    REQ_CLASSIFY = 2'd1,
    REQ_UPDATE   = 2'd2
  } req_t;

endpackage
`default_nettype wire

// File: rtl/chbm_ram.sv
`default_nettype none
module chbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/chbm_div.sv
`default_nettype none
module chbm_div #(
  parameter int COUNT_BITS = chbm_pkg::COUNT_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire [COUNT_BITS-1:0]           num_hi,
  input  wire [chbm_pkg::QUO_BITS-1:0]   num_lo,
  input  wire [COUNT_BITS-1:0]           den,
  output logic                           done,
  output logic [chbm_pkg::QUO_BITS-1:0]  quo
);
  import chbm_pkg::*;

  localparam int STEP_BITS = $clog2(QUO_BITS);

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic [COUNT_BITS-1:0] rem;
  logic [QUO_BITS-1:0]  lo;
  logic [COUNT_BITS:0]  trial;
  logic                 fits;

  // Restoring division, one quotient bit per cycle; num_hi < den on entry
  assign trial = {rem, lo[QUO_BITS-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(QUO_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold the partial remainder and shift in quotient bits
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= num_hi;
      lo  <= num_lo;
    end else if (busy) begin
      lo  <= {lo[QUO_BITS-2:0], 1'b0};
      quo <= {quo[QUO_BITS-2:0], fits};
      if (fits) begin
        rem <= COUNT_BITS'(trial - {1'b0, den});
      end else begin
        rem <= trial[COUNT_BITS-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/color_histogram_background_model.sv
`default_nettype none
// Colour histogram background model. Sample pixels bump a per-frame colour
// histogram held in one RAM; an end-of-frame item blends the histogram into
// a Q0.16 colour model held in a second RAM and clears the histogram; classify
// pixels report foreground when their bin's model value is below threshold,
// once the warm-up count is reached. Sample and classify items go through a
// RAM read, then modify and write back. An end-of-frame item walks every bin
// one at a time: read, multiply, divide in the bit-serial divider (32
// quotient bits), write back; the divider is not started when no samples
// were taken, and a final step posts the result. After reset a clearing pass
// over all 2^(3*BITS_PER_CHANNEL) bins zeroes both RAMs, during which in_ready
// is low. Configuration is taken at any cycle and must be written while idle.
module color_histogram_background_model #(
  parameter int BITS_PER_CHANNEL = chbm_pkg::BITS_PER_CHANNEL_DEF,
  parameter int COUNT_BITS       = chbm_pkg::COUNT_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [chbm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire [chbm_pkg::Q_BITS-1:0]       cfg_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [chbm_pkg::REQ_BITS-1:0]     req_type,
  input  wire [chbm_pkg::CH_BITS-1:0]      blue,
  input  wire [chbm_pkg::CH_BITS-1:0]      green,
  input  wire [chbm_pkg::CH_BITS-1:0]      red,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             foreground,
  output logic                             model_ready
);
  import chbm_pkg::*;

  localparam int BIN_BITS  = 3 * BITS_PER_CHANNEL;
  localparam int NUM_BINS  = 1 << BIN_BITS;
  localparam int PROD_BITS = Q_BITS + COUNT_BITS;
  localparam int KEEP_BITS = Q_BITS + 1;
  localparam int MK_BITS   = Q_BITS + KEEP_BITS;
  localparam int ACC_BITS  = MK_BITS + 1;
  localparam int RND_BITS  = ACC_BITS - Q_BITS;

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_EXEC = 8'b00000100,
    S_URD  = 8'b00001000,
    S_UMUL = 8'b00010000,
    S_UDIV = 8'b00100000,
    S_UWR  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state, state_next;

  logic [Q_BITS-1:0]     alpha, threshold, warmup_frames;
  logic [Q_BITS-1:0]     warmup_count;
  logic [COUNT_BITS-1:0] sample_count;
  logic [BIN_BITS-1:0]   bin;
  logic [BIN_BITS-1:0]   idx_in, idx;
  logic [REQ_BITS-1:0]   req;
  logic                  bin_last, slot_free, ready_now, in_xfer;

  logic                  hist_we, model_we;
  logic [BIN_BITS-1:0]   hist_waddr, raddr;
  logic [COUNT_BITS-1:0] hist_wdata, hist_rd;
  logic [Q_BITS-1:0]     model_wdata, model_rd;

  logic [PROD_BITS-1:0]  prod;
  logic [MK_BITS-1:0]    mk;
  logic [KEEP_BITS-1:0]  keep;
  logic                  div_go, div_done;
  logic [QUO_BITS-1:0]   quo;
  logic [ACC_BITS-1:0]   acc;
  logic [RND_BITS-1:0]   rnd;

  assign idx_in = {red[CH_BITS-1 -: BITS_PER_CHANNEL],
                   green[CH_BITS-1 -: BITS_PER_CHANNEL],
                   blue[CH_BITS-1 -: BITS_PER_CHANNEL]};
  assign bin_last  = bin == {BIN_BITS{1'b1}};
  assign slot_free = !out_valid || out_ready;
  assign ready_now = warmup_count >= warmup_frames;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign in_xfer   = in_valid && in_ready;
  assign keep      = KEEP_BITS'(1 << Q_BITS) - {1'b0, alpha};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha         <= ALPHA_RESET;
      threshold     <= THRESHOLD_RESET;
      warmup_frames <= WARMUP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA:     alpha         <= cfg_data;
        CFG_THRESHOLD: threshold     <= cfg_data;
        CFG_WARMUP:    warmup_frames <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Memories: histogram counts and colour model
  assign raddr = (state == S_IDLE) ? idx_in : ((state == S_EXEC) ? idx : bin);

  always_comb begin
    hist_we     = 1'b0;
    hist_waddr  = bin;
    hist_wdata  = '0;
    model_we    = 1'b0;
    model_wdata = '0;
    unique case (state)
      S_CLR: begin
        hist_we  = 1'b1;
        model_we = 1'b1;
      end
      S_EXEC: begin
        hist_waddr = idx;
        hist_we    = slot_free && (req == REQ_SAMPLE);
        hist_wdata = (hist_rd != {COUNT_BITS{1'b1}}) ? hist_rd + 1'b1 : hist_rd;
      end
      S_UWR: begin
        hist_we     = 1'b1;
        model_we    = 1'b1;
        model_wdata = (rnd > RND_BITS'({Q_BITS{1'b1}})) ? {Q_BITS{1'b1}}
                                                        : rnd[Q_BITS-1:0];
      end
      default: ;
    endcase
  end

  chbm_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(raddr), .rdata(hist_rd)
  );

  chbm_ram #(.WIDTH(Q_BITS), .DEPTH(NUM_BINS)) u_model (
    .clk(clk), .we(model_we), .waddr(bin), .wdata(model_wdata),
    .raddr(raddr), .rdata(model_rd)
  );

  // Contribution divider: floor(alpha*count*2^16 / samples)
  chbm_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_go),
    .num_hi(prod[PROD_BITS-1:Q_BITS]),
    .num_lo({prod[Q_BITS-1:0], {Q_BITS{1'b0}}}),
    .den(sample_count), .done(div_done), .quo(quo)
  );

  // Blend, round half up
  assign acc = ACC_BITS'(mk) + ACC_BITS'(sample_count != '0 ? quo : '0)
             + ACC_BITS'(1 << (Q_BITS - 1));
  assign rnd = acc[ACC_BITS-1:Q_BITS];

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (bin_last) state_next = S_IDLE;
      S_IDLE: if (in_xfer) state_next = (in_ready && req_type == REQ_UPDATE) ? S_URD : S_EXEC;
      S_EXEC: if (slot_free) state_next = S_IDLE;
      S_URD:  state_next = S_UMUL;
      S_UMUL: state_next = S_UDIV;
      S_UDIV: if (sample_count == '0 || div_done) state_next = S_UWR;
      S_UWR:  state_next = bin_last ? S_DONE : S_URD;
      S_DONE: if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      bin          <= '0;
      sample_count <= '0;
      warmup_count <= '0;
      out_valid    <= 1'b0;
      div_go       <= 1'b0;
    end else begin
      state  <= state_next;
      div_go <= (state == S_UMUL) && (sample_count != '0);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: bin <= bin + 1'b1;
        S_EXEC: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (req == REQ_SAMPLE && sample_count != {COUNT_BITS{1'b1}}) begin
              sample_count <= sample_count + 1'b1;
            end
          end
        end
        S_UWR: begin
          bin <= bin + 1'b1;
          if (bin_last) begin
            sample_count <= '0;
            if (ready_now == 1'b0) begin
              warmup_count <= warmup_count + 1'b1;
            end
          end
        end
        S_DONE: if (slot_free) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Item payload, products and result fields
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx <= idx_in;
      req <= req_type;
    end
    if (state == S_UMUL) begin
      prod <= alpha * hist_rd;
      mk   <= model_rd * keep;
    end
    if (state == S_EXEC && slot_free) begin
      foreground  <= (req == REQ_CLASSIFY) && ready_now && (model_rd < threshold);
      model_ready <= ready_now;
    end
    if (state == S_DONE && slot_free) begin
      foreground  <= 1'b0;
      model_ready <= ready_now;
    end
  end

`ifndef SYNTHESIS
  a_fg_needs_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && foreground |-> model_ready)
    else $error("foreground reported before warm-up");

  a_div_in_place: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_UDIV)
    else $error("divider finished outside the divide step");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_UWR && bin_last |=> sample_count == '0)
    else $error("sample count not cleared after model update");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !hist_we && !model_we)
    else $error("memory written while idle");
`endif

endmodule
`default_nettype wire
